// ===== rtl/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helper functions for the sentence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

   // Character codes
   localparam logic [7:0] CHAR_LF     = 8'd10;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_DOLLAR = 8'd36;
   localparam logic [7:0] CHAR_STAR   = 8'd42;
   localparam logic [7:0] CHAR_COMMA  = 8'd44;
   localparam logic [7:0] CHAR_DOT    = 8'd46;
   localparam logic [7:0] CHAR_0      = 8'd48;
   localparam logic [7:0] CHAR_9      = 8'd57;
   localparam logic [7:0] CHAR_A      = 8'd65;
   localparam logic [7:0] CHAR_F      = 8'd70;
   localparam logic [7:0] CHAR_Z      = 8'd90;

   // Register reset values
   localparam logic [6:0] MAX_LENGTH_RST    = 7'd82;
   localparam logic [6:0] MIN_LENGTH_RST    = 7'd12;
   localparam logic [7:0] TALKER_FIRST_RST  = 8'd71;
   localparam logic [7:0] TALKER_SECOND_RST = 8'd80;

   // Register index (word address)
   typedef enum logic [1:0] {
      REG_MAX_LENGTH    = 2'd0,
      REG_MIN_LENGTH    = 2'd1,
      REG_TALKER_FIRST  = 2'd2,
      REG_TALKER_SECOND = 2'd3
   } reg_index_type;

   // Result status codes, first failing check wins
   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_LENGTH   = 3'd1,
      ST_BAD_HEADER   = 3'd2,
      ST_BAD_TAIL     = 3'd3,
      ST_BAD_CHAR     = 3'd4,
      ST_NO_COMMA     = 3'd5,
      ST_SUM_MISMATCH = 3'd6
   } status_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [6:0] max_length;
      logic [6:0] min_length;
      logic [7:0] talker_first;
      logic [7:0] talker_second;
   } cfg_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_0) && (c <= CHAR_9);
   endfunction

   function automatic logic is_hex_digit(input logic [7:0] c);
      return is_digit(c) || ((c >= CHAR_A) && (c <= CHAR_F));
   endfunction

   // Non-hex characters decode as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (is_digit(c)) begin
         d = c - CHAR_0;
      end else if ((c >= CHAR_A) && (c <= CHAR_F)) begin
         d = c - CHAR_A + 8'd10;
      end
      return d[3:0];
   endfunction

   function automatic logic is_body_char(input logic [7:0] c);
      return is_digit(c) || ((c >= CHAR_A) && (c <= CHAR_Z)) ||
             (c == CHAR_DOT) || (c == CHAR_COMMA);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/nsc_csr.sv =====
// ----------------------------------------------------------------------------
// nsc_csr
// APB register file holding length bounds and the expected talker code.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [3:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output nsc_pkg::cfg_type     cfg
);
   import nsc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_MAX_LENGTH:    cfg_in.max_length    = csr_pwdata[6:0];
            REG_MIN_LENGTH:    cfg_in.min_length    = csr_pwdata[6:0];
            REG_TALKER_FIRST:  cfg_in.talker_first  = csr_pwdata[7:0];
            REG_TALKER_SECOND: cfg_in.talker_second = csr_pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length    <= MAX_LENGTH_RST;
         cfg_ff.min_length    <= MIN_LENGTH_RST;
         cfg_ff.talker_first  <= TALKER_FIRST_RST;
         cfg_ff.talker_second <= TALKER_SECOND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         REG_MAX_LENGTH:    csr_prdata = {25'd0, cfg_ff.max_length};
         REG_MIN_LENGTH:    csr_prdata = {25'd0, cfg_ff.min_length};
         REG_TALKER_FIRST:  csr_prdata = {24'd0, cfg_ff.talker_first};
         REG_TALKER_SECOND: csr_prdata = {24'd0, cfg_ff.talker_second};
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/nsc_line.sv =====
// ----------------------------------------------------------------------------
// nsc_line
// Input word register, per-line check state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_line #(
   parameter int COUNT_BITS = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire nsc_pkg::cfg_type  cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_char_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_computed_sum,
   output logic [7:0]             rsp_given_sum,
   output logic [6:0]             rsp_line_length
);
   import nsc_pkg::*;

   localparam int LEN_W = (COUNT_BITS + 1 > 8) ? COUNT_BITS + 1 : 8;
   localparam logic [COUNT_BITS-1:0] POS_MAX    = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] BODY_START = COUNT_BITS'(5);
   localparam logic [COUNT_BITS-1:0] HDR_LEN    = COUNT_BITS'(3);

   // Input word register
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff;
   logic                  take, advance, is_lf;

   // Line state
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic [7:0]            win_ff [4];
   logic [7:0]            win_in [4];
   logic [7:0]            xor_ff, xor_in;
   logic                  hdr_bad_ff, hdr_bad_in;
   logic                  char_bad_ff, char_bad_in;
   logic                  comma_ff, comma_in;
   logic                  long_ff, long_in;

   // Result register
   logic                  out_valid_ff, out_valid_in;
   status_type            status_ff, status_in;
   logic [7:0]            csum_ff;
   logic [7:0]            gsum_ff, gsum_in;
   logic [6:0]            len_ff, len_in;

   logic [LEN_W-1:0]      len_full;
   logic                  long_fin, hdr_fin, tail_ok;

   assign is_lf     = (in_char_ff == CHAR_LF);
   assign advance   = in_valid_ff && (!is_lf || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_char_ff <= req_char_in;
      end
   end

   // End-of-line evaluation
   assign len_full = LEN_W'(pos_ff) + LEN_W'(1);
   assign long_fin = long_ff || (pos_ff == POS_MAX);
   assign hdr_fin  = hdr_bad_ff || (pos_ff < HDR_LEN);
   assign tail_ok  = (win_ff[0] == CHAR_STAR) && is_hex_digit(win_ff[1]) &&
                     is_hex_digit(win_ff[2]) && (win_ff[3] == CHAR_CR);
   assign gsum_in  = {hex_value(win_ff[1]), hex_value(win_ff[2])};

   always_comb begin
      if (long_fin || (len_full > LEN_W'(cfg.max_length)) ||
          (len_full < LEN_W'(cfg.min_length))) begin
         status_in = ST_BAD_LENGTH;
      end else if (hdr_fin) begin
         status_in = ST_BAD_HEADER;
      end else if (!tail_ok) begin
         status_in = ST_BAD_TAIL;
      end else if (char_bad_ff) begin
         status_in = ST_BAD_CHAR;
      end else if (!comma_ff) begin
         status_in = ST_NO_COMMA;
      end else if (gsum_in != xor_ff) begin
         status_in = ST_SUM_MISMATCH;
      end else begin
         status_in = ST_OK;
      end
   end

   assign len_in = (long_fin || (len_full > LEN_W'(127))) ? 7'd127 : len_full[6:0];

   // Per-character state update; a line feed clears the line
   always_comb begin
      pos_in      = pos_ff;
      win_in      = win_ff;
      xor_in      = xor_ff;
      hdr_bad_in  = hdr_bad_ff;
      char_bad_in = char_bad_ff;
      comma_in    = comma_ff;
      long_in     = long_ff;
      if (advance) begin
         if (is_lf) begin
            pos_in      = '0;
            win_in      = '{default: 8'd0};
            xor_in      = 8'd0;
            hdr_bad_in  = 1'b0;
            char_bad_in = 1'b0;
            comma_in    = 1'b0;
            long_in     = 1'b0;
         end else begin
            if ((pos_ff == COUNT_BITS'(0)) && (in_char_ff != CHAR_DOLLAR)) begin
               hdr_bad_in = 1'b1;
            end
            if ((pos_ff == COUNT_BITS'(1)) && (in_char_ff != cfg.talker_first)) begin
               hdr_bad_in = 1'b1;
            end
            if ((pos_ff == COUNT_BITS'(2)) && (in_char_ff != cfg.talker_second)) begin
               hdr_bad_in = 1'b1;
            end
            // oldest window entry leaves as a body character
            if (pos_ff >= BODY_START) begin
               if (!is_body_char(win_ff[0])) begin
                  char_bad_in = 1'b1;
               end
               if (win_ff[0] == CHAR_COMMA) begin
                  comma_in = 1'b1;
               end
               xor_in = xor_ff ^ win_ff[0];
            end
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = win_ff[3];
            win_in[3] = in_char_ff;
            if (pos_ff == POS_MAX) begin
               long_in = 1'b1;
            end else begin
               pos_in = pos_ff + COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         win_ff      <= '{default: 8'd0};
         xor_ff      <= 8'd0;
         hdr_bad_ff  <= 1'b0;
         char_bad_ff <= 1'b0;
         comma_ff    <= 1'b0;
         long_ff     <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         win_ff      <= win_in;
         xor_ff      <= xor_in;
         hdr_bad_ff  <= hdr_bad_in;
         char_bad_ff <= char_bad_in;
         comma_ff    <= comma_in;
         long_ff     <= long_in;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && is_lf) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_lf) begin
         status_ff <= status_in;
         csum_ff   <= xor_ff;
         gsum_ff   <= gsum_in;
         len_ff    <= len_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_computed_sum = csum_ff;
   assign rsp_given_sum    = gsum_ff;
   assign rsp_line_length  = len_ff;

endmodule

`default_nettype wire

// ===== rtl/nmea_sentence_checker.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// NMEA 0183 sentence checker: length, header, tail, body characters, comma and checksum.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one received character per word. A line feed closes
//    the line and produces one result word on the rsp_ channel; other
//    characters produce none.
//  - rsp_status gives the first failing check (length, header, tail, body
//    character, missing comma, checksum), with the computed and received
//    checksums and the line length (saturating at 127).
//  - A character is registered in the input register on acceptance and then
//    folded into the line state; a line feed's result is loaded into the
//    result register when the line feed leaves the input register.
//  - Throughput: one character per cycle, except while a line feed waits for
//    the result register to be free.
//  - When the receiver stalls, the result register holds its word; non line
//    feed characters keep flowing, and a line feed waits in the input register
//    until the result register is free.
//  - Reset clears the line state, the pipeline valids and loads the default
//    register values (length 12..82, talker "GP").
//  - csr_ registers: 0 max_length, 1 min_length, 2 talker_first,
//    3 talker_second, one per 32-bit word; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checker #(
   parameter int COUNT_BITS = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // character input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   // line result
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_computed_sum,
   output logic [7:0]       rsp_given_sum,
   output logic [6:0]       rsp_line_length,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import nsc_pkg::*;

   cfg_type cfg;

   nsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   nsc_line #(
      .COUNT_BITS (COUNT_BITS)
   ) u_line (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_computed_sum (rsp_computed_sum),
      .rsp_given_sum    (rsp_given_sum),
      .rsp_line_length  (rsp_line_length)
   );

endmodule

`default_nettype wire

// ===== rtl/nsc_checker.sv =====
// ----------------------------------------------------------------------------
// nsc_checker
// Port-level checks for the sentence checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [7:0] rsp_computed_sum,
   input wire logic [7:0] rsp_given_sum,
   input wire logic [6:0] rsp_line_length
);
   import nsc_pkg::*;

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_computed_sum) && $stable(rsp_given_sum) &&
         $stable(rsp_line_length))
      else $error("result word changed while stalled");

   // No result right out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Status code range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_SUM_MISMATCH)
      else $error("status code out of range");

   // A passing line has matching checksums
   a_ok_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> rsp_computed_sum == rsp_given_sum)
      else $error("ok status with checksum mismatch");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_computed_sum (rsp_computed_sum),
   .rsp_given_sum    (rsp_given_sum),
   .rsp_line_length  (rsp_line_length)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sentence checker. Characters go in one word at a time on
// the req_ channel. Each accepted word also updates a line tracker kept in the
// testbench. Every line feed puts an expected verdict in a queue, and each
// rsp_ word is compared field by field with the oldest one. Directed lines
// cover each verdict and the length and talker limits. Random phases follow,
// each with its own register setting, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_top;
   import nsc_pkg::*;

   // Expected verdict for one line
   typedef struct packed {
      status_type status;
      logic [7:0] computed;
      logic [7:0] given;
      logic [6:0] length;
   } line_verdict_type;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_type;

   localparam logic [6:0] POS_SAT = 7'h7f;

   // DUT signals; every input is driven to a known value from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_computed_sum;
   logic [7:0]  rsp_given_sum;
   logic [6:0]  rsp_line_length;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Line tracker: register copy and per-line state
   logic [6:0]  lim_max;
   logic [6:0]  lim_min;
   logic [7:0]  talk_a;
   logic [7:0]  talk_b;
   logic [6:0]  line_pos;
   logic [7:0]  tail_win [4];
   logic [7:0]  body_xor;
   logic        hdr_bad;
   logic        char_bad;
   logic        comma_seen;
   logic        overlong;

   line_verdict_type verdict_q [$];
   line_verdict_type head_v;
   logic [7:0]       field_buf [$];
   logic [7:0]       line_buf [$];

   int             fail_count = 0;
   int             burst_left = 0;
   bit             gaps_on = 1'b0;
   int             gap_max = 4;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_cnt = 0;

   nmea_sentence_checker i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_computed_sum (rsp_computed_sum),
      .rsp_given_sum    (rsp_given_sum),
      .rsp_line_length  (rsp_line_length),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #6 clock = ~clock;

   // Run limit, far above the slowest legal run
   initial begin
      #4800000;
      $display("tb_top failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Line tracker
   // ------------------------------------------------------------------------

   // bit 4 flags a valid uppercase hex digit, bits 3:0 hold its value
   function automatic logic [4:0] decode_hex(input logic [7:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return {1'b1, c[3:0]};
      if (c >= CHAR_A && c <= CHAR_F) return {1'b1, c[3:0] + 4'd9};
      return 5'd0;
   endfunction

   function automatic logic body_ok(input logic [7:0] c);
      return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_A && c <= CHAR_Z) ||
             c == CHAR_DOT || c == CHAR_COMMA;
   endfunction

   function automatic void clear_line();
      line_pos = 7'd0;
      tail_win[0] = 8'd0;
      tail_win[1] = 8'd0;
      tail_win[2] = 8'd0;
      tail_win[3] = 8'd0;
      body_xor = 8'd0;
      hdr_bad = 1'b0;
      char_bad = 1'b0;
      comma_seen = 1'b0;
      overlong = 1'b0;
   endfunction

   // Fold one accepted character in; a line feed queues the line's verdict
   function automatic void track_char(input logic [7:0] c);
      line_verdict_type v;
      int               len;
      logic [4:0]       hi;
      logic [4:0]       lo;
      logic             tail_ok;
      if (c != CHAR_LF) begin
         if (line_pos == 7'd0 && c != CHAR_DOLLAR) hdr_bad = 1'b1;
         if (line_pos == 7'd1 && c != talk_a) hdr_bad = 1'b1;
         if (line_pos == 7'd2 && c != talk_b) hdr_bad = 1'b1;
         // the oldest window entry leaves as a body character
         if (line_pos >= 7'd5) begin
            if (!body_ok(tail_win[0])) char_bad = 1'b1;
            if (tail_win[0] == CHAR_COMMA) comma_seen = 1'b1;
            body_xor = body_xor ^ tail_win[0];
         end
         tail_win[0] = tail_win[1];
         tail_win[1] = tail_win[2];
         tail_win[2] = tail_win[3];
         tail_win[3] = c;
         if (line_pos == POS_SAT) overlong = 1'b1;
         else line_pos = line_pos + 7'd1;
      end else begin
         len = int'(line_pos) + 1;
         hi = decode_hex(tail_win[1]);
         lo = decode_hex(tail_win[2]);
         tail_ok = tail_win[0] == CHAR_STAR && hi[4] && lo[4] && tail_win[3] == CHAR_CR;
         if (line_pos == POS_SAT) overlong = 1'b1;
         v.computed = body_xor;
         v.given = {hi[3:0], lo[3:0]};
         v.length = overlong ? 7'd127 : len[6:0];
         // first failing check wins
         if (overlong || len > int'(lim_max) || len < int'(lim_min)) v.status = ST_BAD_LENGTH;
         else if (hdr_bad || line_pos < 7'd3) v.status = ST_BAD_HEADER;
         else if (!tail_ok) v.status = ST_BAD_TAIL;
         else if (char_bad) v.status = ST_BAD_CHAR;
         else if (!comma_seen) v.status = ST_NO_COMMA;
         else if (v.given != body_xor) v.status = ST_SUM_MISMATCH;
         else v.status = ST_OK;
         verdict_q.push_back(v);
         clear_line();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            $error("result word with no line pending, status %0d", rsp_status);
            fail_count++;
         end else begin
            head_v = verdict_q.pop_front();
            check_field("status", 8'(head_v.status), 8'(rsp_status));
            check_field("computed_sum", head_v.computed, rsp_computed_sum);
            check_field("given_sum", head_v.given, rsp_given_sum);
            check_field("line_length", 8'(head_v.length), 8'(rsp_line_length));
         end
      end
   end

   // Receiver stall pattern
   always @(negedge clock) begin
      case (stall_mode)
         STALL_NONE: begin
            rsp_ready <= 1'b1;
         end
         STALL_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            if (stall_cnt > 0) begin
               stall_cnt--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 3) == 0) stall_cnt = $urandom_range(1, 12);
            end
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Sender and register access
   // ------------------------------------------------------------------------

   // One character word; bursts of random length with random gaps between
   task automatic send_char(input logic [7:0] c);
      int gap;
      if (gaps_on && burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_char(c);
      burst_left--;
   endtask

   // Send line_buf; pause_at >= 0 holds off mid-line until all verdicts are in
   task automatic send_line(input int pause_at);
      int i;
      for (i = 0; i < line_buf.size(); i++) begin
         if (i == pause_at) wait_idle();
         send_char(line_buf[i]);
      end
   endtask

   // Stop sending, wait for every pending verdict, then let the pipe settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // APB write followed by a read back of the same register
   task automatic write_reg(input reg_index_type idx, input logic [7:0] value);
      logic [31:0] want;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_MAX_LENGTH: begin
            lim_max = value[6:0];
            want = {25'd0, value[6:0]};
         end
         REG_MIN_LENGTH: begin
            lim_min = value[6:0];
            want = {25'd0, value[6:0]};
         end
         REG_TALKER_FIRST: begin
            talk_a = value;
            want = {24'd0, value};
         end
         default: begin
            talk_b = value;
            want = {24'd0, value};
         end
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) begin
         $error("prdata: expected %0d, actual %0d", want, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_config(input logic [7:0] max_len, input logic [7:0] min_len,
                                 input logic [7:0] first, input logic [7:0] second);
      wait_idle();
      write_reg(REG_MAX_LENGTH, max_len);
      write_reg(REG_MIN_LENGTH, min_len);
      write_reg(REG_TALKER_FIRST, first);
      write_reg(REG_TALKER_SECOND, second);
   endtask

   // ------------------------------------------------------------------------
   // Sentence building
   // ------------------------------------------------------------------------

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? 8'(CHAR_0 + n) : 8'(CHAR_A + n - 4'd10);
   endfunction

   function automatic void fields_from_text(input string s);
      int i;
      field_buf = {};
      for (i = 0; i < s.len(); i++) field_buf.push_back(s[i]);
   endfunction

   // n legal body characters, with or without a comma
   function automatic void random_fields(input int n, input bit with_comma);
      int i;
      int r;
      field_buf = {};
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 39);
         if (r < 10) field_buf.push_back(8'(CHAR_0 + r));
         else if (r < 36) field_buf.push_back(8'(CHAR_A + r - 10));
         else if (r == 36 || !with_comma) field_buf.push_back(CHAR_DOT);
         else field_buf.push_back(CHAR_COMMA);
      end
      if (with_comma && n > 0) field_buf[$urandom_range(0, n - 1)] = CHAR_COMMA;
   endfunction

   // '$', talker, fields, '*', checksum, CR, LF; length is fields + 8
   function automatic void frame_sentence();
      logic [7:0] x;
      int         i;
      line_buf = {};
      line_buf.push_back(CHAR_DOLLAR);
      line_buf.push_back(talk_a);
      line_buf.push_back(talk_b);
      x = talk_a ^ talk_b;
      for (i = 0; i < field_buf.size(); i++) begin
         line_buf.push_back(field_buf[i]);
         x = x ^ field_buf[i];
      end
      line_buf.push_back(CHAR_STAR);
      line_buf.push_back(hex_char(x[7:4]));
      line_buf.push_back(hex_char(x[3:0]));
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
   endfunction

   function automatic void sentence_of_length(input int len, input bit with_comma);
      random_fields((len < 8) ? 0 : len - 8, with_comma);
      frame_sentence();
   endfunction

   // Mostly well-formed lines with random content; the rest broken or noise
   function automatic void build_random_line();
      int kind;
      int pick;
      int len;
      int cut;
      int n;
      kind = $urandom_range(0, 15);
      if (kind == 15) begin
         line_buf = {};
         n = $urandom_range(0, 30);
         repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
         line_buf.push_back(CHAR_LF);
         return;
      end
      pick = $urandom_range(0, 24);
      case (pick)
         0: len = $urandom_range(120, 140);
         1: len = int'(lim_min) - $urandom_range(0, 1);
         2: len = int'(lim_max);
         3: len = int'(lim_max) + 1;
         default: len = $urandom_range(int'(lim_min), int'(lim_min) + 24);
      endcase
      if (len < 8) len = 8;
      sentence_of_length(len, kind != 14);
      n = line_buf.size();
      case (kind)
         8: line_buf[$urandom_range(0, n - 2)] = 8'($urandom_range(0, 255));
         9: line_buf[n - 4 + $urandom_range(0, 1)] = hex_char(4'($urandom_range(0, 15)));
         10: line_buf.delete(n - 2);
         11: line_buf[$urandom_range(1, 2)] = 8'($urandom_range(0, 255));
         12: line_buf[0] = 8'($urandom_range(0, 255));
         13: begin
            cut = $urandom_range(0, n - 1);
            while (line_buf.size() > cut) void'(line_buf.pop_back());
            line_buf.push_back(CHAR_LF);
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // At least one line per verdict with the reset configuration (12..82, talker "GP")
   task automatic test_default_config();
      gaps_on = 1'b0;
      stall_mode = STALL_NONE;
      // good sentence
      fields_from_text("GGA,123.45,N");
      frame_sentence();
      send_line(-1);
      // checksum mismatch
      frame_sentence();
      line_buf[line_buf.size() - 3] =
         (line_buf[line_buf.size() - 3] == CHAR_0) ? CHAR_9 : CHAR_0;
      send_line(-1);
      // no comma in body
      fields_from_text("GGA12345.6");
      frame_sentence();
      send_line(-1);
      // illegal body characters, the extreme codes among them
      fields_from_text("GSV,1,2");
      field_buf[4] = 8'h00;
      field_buf.push_back(8'hff);
      frame_sentence();
      send_line(-1);
      // lowercase checksum digit decodes as zero, bad tail
      fields_from_text("RMC,A,9");
      frame_sentence();
      line_buf[line_buf.size() - 4] = 8'h61;
      send_line(-1);
      // CR missing
      frame_sentence();
      line_buf.delete(line_buf.size() - 2);
      send_line(-1);
      // wrong talker
      frame_sentence();
      line_buf[2] = 8'h4e;
      send_line(-1);
      // no leading dollar
      frame_sentence();
      line_buf[0] = 8'h21;
      send_line(-1);
      // lone line feed, then a line cut short after two characters
      line_buf = {CHAR_LF};
      send_line(-1);
      line_buf = {CHAR_DOLLAR, 8'h47, CHAR_LF};
      send_line(-1);
   endtask

   // Bounds at their extremes, lengths on and around each bound
   task automatic test_length_bounds();
      int lens[] = '{8, 9, 126, 128};
      int i;
      gaps_on = 1'b1;
      gap_max = 3;
      stall_mode = STALL_RANDOM;
      // the longest line also saturates the count
      program_config(8'd126, 8'd8, TALKER_FIRST_RST, TALKER_SECOND_RST);
      for (i = 0; i < lens.size(); i++) begin
         sentence_of_length(lens[i], lens[i] > 8);
         send_line(-1);
      end
      program_config(8'd12, 8'd12, TALKER_FIRST_RST, TALKER_SECOND_RST);
      for (i = 11; i <= 13; i++) begin
         sentence_of_length(i, 1'b1);
         send_line(-1);
      end
      // lower bound above upper bound: every line fails on length
      program_config(8'd12, 8'd82, TALKER_FIRST_RST, TALKER_SECOND_RST);
      for (i = 12; i <= 47; i += 35) begin
         sentence_of_length(i, 1'b1);
         send_line(-1);
      end
   endtask

   // Talker codes at the extremes and a second legal pair
   task automatic test_talker_values();
      gaps_on = 1'b1;
      gap_max = 6;
      stall_mode = STALL_LONG;
      program_config(8'd82, 8'd12, 8'h00, 8'hff);
      sentence_of_length(20, 1'b1);
      send_line(-1);
      sentence_of_length(20, 1'b1);
      line_buf[1] = 8'hff;
      send_line(-1);
      program_config(8'd82, 8'd12, 8'hff, 8'h00);
      sentence_of_length(16, 1'b1);
      send_line(-1);
      program_config(8'd82, 8'd12, CHAR_A, CHAR_Z);
      sentence_of_length(24, 1'b1);
      send_line(-1);
      sentence_of_length(24, 1'b1);
      line_buf[1] = CHAR_Z;
      send_line(-1);
   endtask

   // Random phases, each with its own setting, idling and stall pattern
   task automatic test_random_traffic();
      int         ph;
      int         chars;
      int         lines;
      int         pause_at;
      bit         pause_pending;
      logic [7:0] first;
      logic [7:0] second;
      for (ph = 0; ph < 6; ph++) begin
         if (ph == 4) begin
            first = 8'($urandom_range(0, 255));
            second = 8'($urandom_range(0, 255));
         end else begin
            first = 8'($urandom_range(CHAR_A, CHAR_Z));
            second = 8'($urandom_range(CHAR_A, CHAR_Z));
         end
         program_config(8'($urandom_range(30, 126)), 8'($urandom_range(8, 16)),
                        first, second);
         stall_mode = stall_mode_type'(ph % 3);
         gaps_on = (ph != 1);
         gap_max = (ph == 2) ? 12 : 4;
         pause_pending = (ph == 3);
         chars = 0;
         lines = 0;
         while (chars < 16 || lines < 1) begin
            build_random_line();
            pause_at = -1;
            if (pause_pending && line_buf.size() > 4) begin
               pause_at = line_buf.size() / 2;
               pause_pending = 1'b0;
            end
            send_line(pause_at);
            chars += line_buf.size();
            lines++;
         end
      end
   endtask

   // Test sequence
   initial begin
      lim_max = MAX_LENGTH_RST;
      lim_min = MIN_LENGTH_RST;
      talk_a = TALKER_FIRST_RST;
      talk_b = TALKER_SECOND_RST;
      clear_line();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_config();
      test_length_bounds();
      test_talker_values();
      test_random_traffic();

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
